// ===== design/density_charge_window_force_top_macros.svh =====
`ifndef DENSITY_CHARGE_WINDOW_FORCE_TOP_MACROS_SVH
`define DENSITY_CHARGE_WINDOW_FORCE_TOP_MACROS_SVH

// checked only out of reset
`define DCWF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dcwf assertion failed");

// checked during reset too
`define DCWF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dcwf reset assertion failed");

`endif

// ===== design/dcwf_pkg.sv =====
package dcwf_pkg;

  localparam int MAX_COLS_DEF  = 256;
  localparam int MAX_ROWS_DEF  = 256;
  localparam int MAX_REACH_DEF = 16;

  localparam int CNT_W      = 9;
  localparam int BSZ_W      = 20;
  localparam int CRD_W      = 32;
  localparam int RAD_W      = 24;
  localparam int OCC_W      = 32;
  localparam int ADR_W      = 16;
  localparam int FRC_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DAT_W  = 32;
  localparam int DIFF_W     = CRD_W + 1;
  localparam int DVD_W      = CRD_W;
  localparam int RCH_W      = 7;
  localparam int DIST_W     = 36;
  localparam int STEP_CNT_W = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS  = 3'd0,
    CFG_GRID_ROWS  = 3'd1,
    CFG_BIN_WIDTH  = 3'd2,
    CFG_BIN_HEIGHT = 3'd3,
    CFG_ORIGIN_X   = 3'd4,
    CFG_ORIGIN_Y   = 3'd5,
    CFG_CAPACITY   = 3'd6,
    CFG_RADIUS     = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_X  = 2'd0,
    DIV_Y  = 2'd1,
    DIV_RX = 2'd2,
    DIV_RY = 2'd3
  } div_sel_t;

  typedef struct packed {
    logic     wr;
    logic     load;
    logic     div_start;
    logic     div_step;
    logic     div_save;
    div_sel_t div_sel;
    logic     setup;
    logic     row0;
    logic     step;
    logic     publish;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== design/density_charge_window_force_top.sv =====
// Density charge window force.
// Input channel (in_valid/in_ready): a write transaction (in_operation 0)
// stores in_bin_occupancy at in_bin_index and returns nothing; a query
// transaction (in_operation 1) returns one result on the out_ channel.
// Config port: cfg_we, cfg_index, cfg_data, written only while idle: a rule
// for the user, which the block does not enforce. Write: the next transaction
// can follow directly. Query: four 32-step divisions on the shared
// restoring divider, then the setup and row0 steps, then one bin per cycle
// of the clamped window (one read of the occupancy RAM port each), then the
// drain and fin steps to the output register.
// A query window is at most (2*MAX_REACH+1)^2 bins.
// The next transaction is taken while a result waits in the output register;
// a finished query waits until that register is free.
// Reset (rst_n low, synchronous) clears control state and restores the
// configuration defaults; occupancy RAM contents are not cleared.
module density_charge_window_force_top #(
  parameter int MAX_COLS  = dcwf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = dcwf_pkg::MAX_ROWS_DEF,
  parameter int MAX_REACH = dcwf_pkg::MAX_REACH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [dcwf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dcwf_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [dcwf_pkg::ADR_W-1:0]        in_bin_index,
  input  logic [dcwf_pkg::OCC_W-1:0]        in_bin_occupancy,
  input  logic signed [dcwf_pkg::CRD_W-1:0] in_node_x,
  input  logic signed [dcwf_pkg::CRD_W-1:0] in_node_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dcwf_pkg::FRC_W-1:0] out_force_x,
  output logic signed [dcwf_pkg::FRC_W-1:0] out_force_y
);

  dcwf_pkg::dp_cmd_t cmd;
  dcwf_pkg::dp_sts_t sts;

  dcwf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  dcwf_dp #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .MAX_REACH (MAX_REACH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_bin_index     (in_bin_index),
    .in_bin_occupancy (in_bin_occupancy),
    .in_node_x        (in_node_x),
    .in_node_y        (in_node_y),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_force_x      (out_force_x),
    .out_force_y      (out_force_y)
  );

endmodule

// ===== design/dcwf_ctrl.sv =====
module dcwf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_ready,
  output dcwf_pkg::dp_cmd_t cmd,
  input  dcwf_pkg::dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_DSTART, S_DSTEP, S_DSAVE, S_SETUP, S_ROW0, S_WALK, S_DRAIN, S_FIN
  } state_t;

  state_t                                state_r, state_nxt;
  dcwf_pkg::div_sel_t                    sel_r, sel_nxt;
  logic [dcwf_pkg::STEP_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                                  in_ready_r;
  logic                                  accept;

  assign in_ready = in_ready_r;
  assign accept   = in_valid & in_ready_r;

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.div_sel = sel_r;
    case (state_r)
      S_IDLE: begin
        cmd.wr   = accept & (in_operation == dcwf_pkg::OP_WRITE);
        cmd.load = accept & (in_operation == dcwf_pkg::OP_QUERY);
        if (cmd.load) begin
          state_nxt = S_DSTART;
          sel_nxt   = dcwf_pkg::DIV_X;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == dcwf_pkg::STEP_CNT_W'(dcwf_pkg::DVD_W - 1)) begin
          state_nxt = S_DSAVE;
        end
      end
      S_DSAVE: begin
        cmd.div_save = 1'b1;
        if (sel_r == dcwf_pkg::DIV_RY) begin
          state_nxt = S_SETUP;
        end else begin
          sel_nxt   = dcwf_pkg::div_sel_t'(sel_r + 2'd1);
          state_nxt = S_DSTART;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_ROW0;
      end
      S_ROW0: begin
        cmd.row0  = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      sel_r      <= dcwf_pkg::DIV_X;
      cnt_r      <= '0;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      sel_r      <= sel_nxt;
      cnt_r      <= cnt_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

// ===== design/dcwf_dp.sv =====
module dcwf_dp #(
  parameter int MAX_COLS  = dcwf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = dcwf_pkg::MAX_ROWS_DEF,
  parameter int MAX_REACH = dcwf_pkg::MAX_REACH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [dcwf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dcwf_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic [dcwf_pkg::ADR_W-1:0]           in_bin_index,
  input  logic [dcwf_pkg::OCC_W-1:0]           in_bin_occupancy,
  input  logic signed [dcwf_pkg::CRD_W-1:0]    in_node_x,
  input  logic signed [dcwf_pkg::CRD_W-1:0]    in_node_y,
  input  dcwf_pkg::dp_cmd_t                    cmd,
  output dcwf_pkg::dp_sts_t                    sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dcwf_pkg::FRC_W-1:0]    out_force_x,
  output logic signed [dcwf_pkg::FRC_W-1:0]    out_force_y
);

  localparam int CNT_W  = dcwf_pkg::CNT_W;
  localparam int BSZ_W  = dcwf_pkg::BSZ_W;
  localparam int CRD_W  = dcwf_pkg::CRD_W;
  localparam int RAD_W  = dcwf_pkg::RAD_W;
  localparam int OCC_W  = dcwf_pkg::OCC_W;
  localparam int ADR_W  = dcwf_pkg::ADR_W;
  localparam int FRC_W  = dcwf_pkg::FRC_W;
  localparam int DIFF_W = dcwf_pkg::DIFF_W;
  localparam int DVD_W  = dcwf_pkg::DVD_W;
  localparam int RCH_W  = dcwf_pkg::RCH_W;
  localparam int DIST_W = dcwf_pkg::DIST_W;
  localparam int PRD_W  = CNT_W + 1 + BSZ_W;
  localparam int Q_W    = OCC_W + 2;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v, input int mx);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (int'(v) > mx) r = CNT_W'(mx);
    else r = v;
    return r;
  endfunction

  // configuration
  logic [CNT_W-1:0]        grid_cols_r, grid_rows_r;
  logic [BSZ_W-1:0]        bin_width_r, bin_height_r;
  logic signed [CRD_W-1:0] origin_x_r, origin_y_r;
  logic [OCC_W-1:0]        capacity_r;
  logic [RAD_W-1:0]        radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r  <= CNT_W'(1);
      grid_rows_r  <= CNT_W'(1);
      bin_width_r  <= BSZ_W'(1);
      bin_height_r <= BSZ_W'(1);
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      capacity_r   <= '0;
      radius_r     <= RAD_W'(4);
    end else if (cfg_we) begin
      case (dcwf_pkg::cfg_idx_t'(cfg_index))
        dcwf_pkg::CFG_GRID_COLS:  grid_cols_r  <= cfg_data[CNT_W-1:0];
        dcwf_pkg::CFG_GRID_ROWS:  grid_rows_r  <= cfg_data[CNT_W-1:0];
        dcwf_pkg::CFG_BIN_WIDTH:  bin_width_r  <= cfg_data[BSZ_W-1:0];
        dcwf_pkg::CFG_BIN_HEIGHT: bin_height_r <= cfg_data[BSZ_W-1:0];
        dcwf_pkg::CFG_ORIGIN_X:   origin_x_r   <= cfg_data[CRD_W-1:0];
        dcwf_pkg::CFG_ORIGIN_Y:   origin_y_r   <= cfg_data[CRD_W-1:0];
        dcwf_pkg::CFG_CAPACITY:   capacity_r   <= cfg_data[OCC_W-1:0];
        dcwf_pkg::CFG_RADIUS:     radius_r     <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] cols_c, rows_c, colsm1_c, rowsm1_c;
  logic [BSZ_W-1:0] bw_c, bh_c;

  assign cols_c   = clamp_cnt(grid_cols_r, MAX_COLS);
  assign rows_c   = clamp_cnt(grid_rows_r, MAX_ROWS);
  assign colsm1_c = cols_c - 1'b1;
  assign rowsm1_c = rows_c - 1'b1;
  assign bw_c     = (bin_width_r == '0) ? BSZ_W'(1) : bin_width_r;
  assign bh_c     = (bin_height_r == '0) ? BSZ_W'(1) : bin_height_r;

  // node offsets from origin
  logic signed [DIFF_W-1:0] dxn_r, dyn_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dxn_r <= DIFF_W'(in_node_x) - DIFF_W'(origin_x_r);
      dyn_r <= DIFF_W'(in_node_y) - DIFF_W'(origin_y_r);
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DVD_W-1:0] dvd_r;
  logic [BSZ_W-1:0] rem_r, dsr_r;
  logic [BSZ_W:0]   rem_sh;
  logic [BSZ_W+1:0] rem_sub;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      case (cmd.div_sel)
        dcwf_pkg::DIV_X:  begin dvd_r <= dxn_r[DVD_W-1:0];  dsr_r <= bw_c; end
        dcwf_pkg::DIV_Y:  begin dvd_r <= dyn_r[DVD_W-1:0];  dsr_r <= bh_c; end
        dcwf_pkg::DIV_RX: begin dvd_r <= DVD_W'(radius_r); dsr_r <= bw_c; end
        dcwf_pkg::DIV_RY: begin dvd_r <= DVD_W'(radius_r); dsr_r <= bh_c; end
        default:          begin dvd_r <= '0;               dsr_r <= bw_c; end
      endcase
    end else if (cmd.div_step) begin
      if (!rem_sub[BSZ_W+1]) begin
        rem_r <= rem_sub[BSZ_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[BSZ_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  // center bin and reach
  logic [CNT_W-1:0] cx_r, cy_r;
  logic [RCH_W-1:0] rx_r, ry_r;
  logic [RCH_W-1:0] reach_c;

  assign reach_c = (dvd_r >= DVD_W'(MAX_REACH)) ? RCH_W'(MAX_REACH)
                                                : dvd_r[RCH_W-1:0] + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.div_save) begin
      case (cmd.div_sel)
        dcwf_pkg::DIV_X:
          cx_r <= dxn_r[DIFF_W-1] ? '0 :
                  (dvd_r > DVD_W'(colsm1_c)) ? colsm1_c : dvd_r[CNT_W-1:0];
        dcwf_pkg::DIV_Y:
          cy_r <= dyn_r[DIFF_W-1] ? '0 :
                  (dvd_r > DVD_W'(rowsm1_c)) ? rowsm1_c : dvd_r[CNT_W-1:0];
        dcwf_pkg::DIV_RX: rx_r <= reach_c;
        dcwf_pkg::DIV_RY: ry_r <= reach_c;
        default: ;
      endcase
    end
  end

  // window bounds
  logic [CNT_W-1:0] x0_r, x1_r, y0_r, y1_r;
  logic [CNT_W:0]   cxe, cye, rxe, rye, xhi, yhi, xlo, ylo;

  assign cxe = {1'b0, cx_r};
  assign cye = {1'b0, cy_r};
  assign rxe = (CNT_W+1)'(rx_r);
  assign rye = (CNT_W+1)'(ry_r);
  assign xlo = cxe - rxe;
  assign ylo = cye - rye;
  assign xhi = cxe + rxe;
  assign yhi = cye + rye;

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x0_r <= (cxe >= rxe) ? xlo[CNT_W-1:0] : '0;
      y0_r <= (cye >= rye) ? ylo[CNT_W-1:0] : '0;
      x1_r <= (xhi > {1'b0, colsm1_c}) ? colsm1_c : xhi[CNT_W-1:0];
      y1_r <= (yhi > {1'b0, rowsm1_c}) ? rowsm1_c : yhi[CNT_W-1:0];
    end
  end

  // walk state
  logic [CNT_W-1:0]         xx_r, yy_r;
  logic [ADR_W-1:0]         rowb_r;
  logic signed [DIST_W-1:0] dx2_r, dy2_r, dx2s_r;
  logic [PRD_W-1:0]         xprod, yprod;
  logic [2*CNT_W-1:0]       rprod;
  logic signed [DIST_W-1:0] dx2_base, dy2_base, bw2, bh2;

  assign xprod    = {x0_r, 1'b1} * bw_c;
  assign yprod    = {y0_r, 1'b1} * bh_c;
  assign rprod    = y0_r * cols_c;
  assign dx2_base = {{(DIST_W-DIFF_W-1){dxn_r[DIFF_W-1]}}, dxn_r, 1'b0}
                  - $signed({{(DIST_W-PRD_W){1'b0}}, xprod});
  assign dy2_base = {{(DIST_W-DIFF_W-1){dyn_r[DIFF_W-1]}}, dyn_r, 1'b0}
                  - $signed({{(DIST_W-PRD_W){1'b0}}, yprod});
  assign bw2      = $signed({{(DIST_W-BSZ_W-1){1'b0}}, bw_c, 1'b0});
  assign bh2      = $signed({{(DIST_W-BSZ_W-1){1'b0}}, bh_c, 1'b0});

  logic                     row_end;
  logic [DIST_W-1:0]        ax, ay;
  logic [DIST_W:0]          man;
  logic                     inr;
  logic [ADR_W-1:0]         addr_c;

  assign row_end = (xx_r == x1_r);
  assign ax      = dx2_r[DIST_W-1] ? DIST_W'(-dx2_r) : DIST_W'(dx2_r);
  assign ay      = dy2_r[DIST_W-1] ? DIST_W'(-dy2_r) : DIST_W'(dy2_r);
  assign man     = {1'b0, ax} + {1'b0, ay};
  assign inr     = man < (DIST_W+1)'({radius_r, 1'b0});
  assign addr_c  = rowb_r + ADR_W'(xx_r);

  assign sts.walk_last = row_end && (yy_r == y1_r);

  always_ff @(posedge clk) begin
    if (cmd.row0) begin
      xx_r   <= x0_r;
      yy_r   <= y0_r;
      rowb_r <= rprod[ADR_W-1:0];
      dx2s_r <= dx2_base;
      dx2_r  <= dx2_base;
      dy2_r  <= dy2_base;
    end else if (cmd.step) begin
      if (row_end) begin
        xx_r   <= x0_r;
        dx2_r  <= dx2s_r;
        yy_r   <= yy_r + 1'b1;
        dy2_r  <= dy2_r - bh2;
        rowb_r <= rowb_r + ADR_W'(cols_c);
      end else begin
        xx_r  <= xx_r + 1'b1;
        dx2_r <= dx2_r - bw2;
      end
    end
  end

  // occupancy memory
  logic [OCC_W-1:0] mem [2**ADR_W];
  logic [OCC_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[in_bin_index] <= in_bin_occupancy;
    end
    rdata_r <= mem[addr_c];
  end

  // accumulate
  logic                    p1_v_r, p1_sx_r, p1_sy_r;
  logic signed [Q_W-1:0]   q;
  logic signed [FRC_W-1:0] qe, fx_r, fy_r;

  assign q  = $signed({2'b00, rdata_r}) - $signed({2'b00, capacity_r});
  assign qe = {{(FRC_W-Q_W){q[Q_W-1]}}, q};

  always_ff @(posedge clk) begin
    p1_sx_r <= !dx2_r[DIST_W-1];
    p1_sy_r <= !dy2_r[DIST_W-1];
    if (cmd.load) begin
      fx_r <= '0;
      fy_r <= '0;
    end else if (p1_v_r) begin
      fx_r <= p1_sx_r ? fx_r - qe : fx_r + qe;
      fy_r <= p1_sy_r ? fy_r - qe : fy_r + qe;
    end
  end

  // output register
  logic                    out_valid_r;
  logic signed [FRC_W-1:0] force_x_r, force_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.step & inr;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      force_x_r <= fx_r;
      force_y_r <= fy_r;
    end
  end

  assign sts.out_busy = out_valid_r & ~out_ready;
  assign out_valid    = out_valid_r;
  assign out_force_x  = force_x_r;
  assign out_force_y  = force_y_r;

endmodule

// ===== design/dcwf_chk.sv =====
`include "density_charge_window_force_top_macros.svh"

module dcwf_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_operation,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [dcwf_pkg::FRC_W-1:0] out_force_x,
  input logic signed [dcwf_pkg::FRC_W-1:0] out_force_y
);

  `DCWF_ASSERT_RST(a_reset_idle, !rst_n |=> in_ready && !out_valid)
  `DCWF_ASSERT(a_query_busy, in_valid && in_ready && in_operation |=> !in_ready)
  `DCWF_ASSERT(a_write_silent, in_valid && in_ready && !in_operation && !out_valid |=> !out_valid)
  `DCWF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_force_x) && $stable(out_force_y))

endmodule

bind density_charge_window_force_top dcwf_chk u_chk (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct {
    logic signed [dcwf_pkg::FRC_W-1:0] fx;
    logic signed [dcwf_pkg::FRC_W-1:0] fy;
  } force_t;

  typedef struct {
    int unsigned addr;
    bit          neg_x;
    bit          neg_y;
  } bin_hit_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [dcwf_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [dcwf_pkg::CFG_DAT_W-1:0]    cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              in_operation = dcwf_pkg::OP_WRITE;
  logic [dcwf_pkg::ADR_W-1:0]        in_bin_index = '0;
  logic [dcwf_pkg::OCC_W-1:0]        in_bin_occupancy = '0;
  logic signed [dcwf_pkg::CRD_W-1:0] in_node_x = '0;
  logic signed [dcwf_pkg::CRD_W-1:0] in_node_y = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [dcwf_pkg::FRC_W-1:0] out_force_x;
  logic signed [dcwf_pkg::FRC_W-1:0] out_force_y;

  density_charge_window_force_top dut (.*);

  // shadow of the configuration and the occupancy grid
  logic [8:0]  sh_cols, sh_rows;
  logic [19:0] sh_bw, sh_bh;
  longint      sh_org_x, sh_org_y;
  logic [31:0] sh_cap;
  logic [23:0] sh_radius;
  bit [31:0]   occ_mem [0:65535];
  bit          occ_set [0:65535];

  force_t      force_q[$];
  int          errors = 0;
  int unsigned cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          items_sent = 0;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    force_t want;
    if (rst_n && out_valid && out_ready) begin
      if (force_q.size() == 0) begin
        report($sformatf("unexpected result fx=%0d fy=%0d", out_force_x, out_force_y));
      end else begin
        want = force_q.pop_front();
        if (out_force_x !== want.fx)
          report($sformatf("force_x got %0d want %0d", out_force_x, want.fx));
        if (out_force_y !== want.fy)
          report($sformatf("force_y got %0d want %0d", out_force_y, want.fy));
      end
    end
  end

  function automatic longint bin_of(longint diff, longint size, longint count);
    longint k;
    if (diff < 0) return 0;
    k = diff / size;
    return (k > count - 1) ? count - 1 : k;
  endfunction

  // bins of the clamped window whose centres lie inside the radius
  function automatic void scan_window(input logic [31:0] nx, input logic [31:0] ny,
                                      output bin_hit_t hits[$]);
    longint cols, rows, bw, bh, dxn, dyn, cx, cy, rx, ry, x0, x1, y0, y1;
    longint dx2, dy2, ax, ay, lim;
    bin_hit_t h;
    hits = {};
    cols = (sh_cols == 0) ? 1 :
           (sh_cols > dcwf_pkg::MAX_COLS_DEF) ? dcwf_pkg::MAX_COLS_DEF : sh_cols;
    rows = (sh_rows == 0) ? 1 :
           (sh_rows > dcwf_pkg::MAX_ROWS_DEF) ? dcwf_pkg::MAX_ROWS_DEF : sh_rows;
    bw = (sh_bw == 0) ? 1 : sh_bw;
    bh = (sh_bh == 0) ? 1 : sh_bh;
    dxn = longint'(signed'(nx)) - sh_org_x;
    dyn = longint'(signed'(ny)) - sh_org_y;
    cx = bin_of(dxn, bw, cols);
    cy = bin_of(dyn, bh, rows);
    rx = longint'(sh_radius) / bw + 1;
    ry = longint'(sh_radius) / bh + 1;
    if (rx > dcwf_pkg::MAX_REACH_DEF) rx = dcwf_pkg::MAX_REACH_DEF;
    if (ry > dcwf_pkg::MAX_REACH_DEF) ry = dcwf_pkg::MAX_REACH_DEF;
    x0 = (cx - rx < 0) ? 0 : cx - rx;
    x1 = (cx + rx > cols - 1) ? cols - 1 : cx + rx;
    y0 = (cy - ry < 0) ? 0 : cy - ry;
    y1 = (cy + ry > rows - 1) ? rows - 1 : cy + ry;
    lim = 2 * longint'(sh_radius);
    for (longint yy = y0; yy <= y1; yy++) begin
      for (longint xx = x0; xx <= x1; xx++) begin
        dx2 = 2 * dxn - (2 * xx + 1) * bw;
        dy2 = 2 * dyn - (2 * yy + 1) * bh;
        ax = (dx2 < 0) ? -dx2 : dx2;
        ay = (dy2 < 0) ? -dy2 : dy2;
        if (ax + ay < lim) begin
          h.addr = int'((yy * cols + xx) & 16'hFFFF);
          h.neg_x = (dx2 < 0);
          h.neg_y = (dy2 < 0);
          hits.push_back(h);
        end
      end
    end
  endfunction

  function automatic force_t charge_force(input logic [31:0] nx, input logic [31:0] ny);
    bin_hit_t hits[$];
    longint fx, fy, q;
    force_t f;
    fx = 0;
    fy = 0;
    scan_window(nx, ny, hits);
    foreach (hits[i]) begin
      q = longint'(occ_mem[hits[i].addr]) - longint'(sh_cap);
      fx -= hits[i].neg_x ? -q : q;
      fy -= hits[i].neg_y ? -q : q;
    end
    f.fx = fx[dcwf_pkg::FRC_W-1:0];
    f.fy = fy[dcwf_pkg::FRC_W-1:0];
    return f;
  endfunction

  task automatic send_item(input logic op, input logic [15:0] idx, input logic [31:0] occ,
                           input logic [31:0] nx, input logic [31:0] ny);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_operation = op;
    in_bin_index = idx;
    in_bin_occupancy = occ;
    in_node_x = nx;
    in_node_y = ny;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op == dcwf_pkg::OP_WRITE) begin
      occ_mem[idx] = occ;
      occ_set[idx] = 1'b1;
    end else begin
      force_q.push_back(charge_force(nx, ny));
    end
  endtask

  task automatic write_bin(input logic [15:0] idx, input logic [31:0] occ);
    send_item(dcwf_pkg::OP_WRITE, idx, occ, $urandom, $urandom);
  endtask

  // loads every bin inside the radius that the query will use and that has not been loaded yet
  task automatic send_query(input logic [31:0] nx, input logic [31:0] ny);
    bin_hit_t hits[$];
    scan_window(nx, ny, hits);
    foreach (hits[i])
      if (!occ_set[hits[i].addr]) write_bin(hits[i].addr[15:0], $urandom);
    send_item(dcwf_pkg::OP_QUERY, 16'($urandom), $urandom, nx, ny);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input dcwf_pkg::cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      dcwf_pkg::CFG_GRID_COLS:  sh_cols = val[8:0];
      dcwf_pkg::CFG_GRID_ROWS:  sh_rows = val[8:0];
      dcwf_pkg::CFG_BIN_WIDTH:  sh_bw = val[19:0];
      dcwf_pkg::CFG_BIN_HEIGHT: sh_bh = val[19:0];
      dcwf_pkg::CFG_ORIGIN_X:   sh_org_x = longint'(signed'(val));
      dcwf_pkg::CFG_ORIGIN_Y:   sh_org_y = longint'(signed'(val));
      dcwf_pkg::CFG_CAPACITY:   sh_cap = val;
      dcwf_pkg::CFG_RADIUS:     sh_radius = val[23:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_count();
    case ($urandom_range(9))
      0: return 0;
      1: return 256;
      2: return 300 + $urandom_range(211);
      3: return 1;
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(9))
      0: return 0;
      1: return 32'hFFFFF;
      2: return 1;
      3: return $urandom;
      default: return $urandom_range(2, 2000);
    endcase
  endfunction

  task automatic random_setup();
    logic [31:0] big;
    cfg_write(dcwf_pkg::CFG_GRID_COLS, rand_count());
    cfg_write(dcwf_pkg::CFG_GRID_ROWS, rand_count());
    cfg_write(dcwf_pkg::CFG_BIN_WIDTH, rand_size());
    cfg_write(dcwf_pkg::CFG_BIN_HEIGHT, rand_size());
    cfg_write(dcwf_pkg::CFG_ORIGIN_X, $urandom);
    cfg_write(dcwf_pkg::CFG_ORIGIN_Y, $urandom);
    cfg_write(dcwf_pkg::CFG_CAPACITY,
              ($urandom_range(1) != 0) ? $urandom : $urandom_range(0, 1000));
    big = (sh_bw > sh_bh) ? sh_bw : sh_bh;
    if (big == 0) big = 1;
    case ($urandom_range(11))
      0: cfg_write(dcwf_pkg::CFG_RADIUS, 0);
      1: cfg_write(dcwf_pkg::CFG_RADIUS, 32'hFFFFFF);
      2: cfg_write(dcwf_pkg::CFG_RADIUS, $urandom);
      default: cfg_write(dcwf_pkg::CFG_RADIUS, $urandom_range(1, 4 * big));
    endcase
  endtask

  function automatic logic [31:0] rand_coord(input longint org, input logic [19:0] sz,
                                             input logic [8:0] cnt);
    longint span, s;
    s = (sz == 0) ? 1 : sz;
    span = s * ((cnt == 0) ? 1 : cnt) + 2 * s;
    if ($urandom_range(9) == 0) return $urandom;
    return 32'(org - s + longint'($urandom_range(0, 32'(span))));
  endfunction

  task automatic test_directed();
    send_query(32'h0, 32'h0);
    send_query(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_query(32'h80000000, 32'h80000000);
    write_bin(16'hFFFF, 32'hFFFFFFFF);
    write_bin(16'hFFFF, 32'h0);
    wait_idle();
    cfg_write(dcwf_pkg::CFG_GRID_COLS, 0);
    cfg_write(dcwf_pkg::CFG_GRID_ROWS, 300);
    cfg_write(dcwf_pkg::CFG_BIN_WIDTH, 0);
    cfg_write(dcwf_pkg::CFG_BIN_HEIGHT, 0);
    cfg_write(dcwf_pkg::CFG_CAPACITY, 32'hFFFFFFFF);
    send_query(32'd5, 32'd9);
    send_query(32'hFFFFFFFF, 32'd600);
    wait_idle();
    cfg_write(dcwf_pkg::CFG_RADIUS, 0);
    send_query(32'd3, 32'd3);
    wait_idle();
    cfg_write(dcwf_pkg::CFG_GRID_COLS, 256);
    cfg_write(dcwf_pkg::CFG_GRID_ROWS, 256);
    cfg_write(dcwf_pkg::CFG_BIN_WIDTH, 32'hFFFFF);
    cfg_write(dcwf_pkg::CFG_BIN_HEIGHT, 7);
    cfg_write(dcwf_pkg::CFG_ORIGIN_X, 32'h80000000);
    cfg_write(dcwf_pkg::CFG_ORIGIN_Y, 32'h7FFFFFFF);
    cfg_write(dcwf_pkg::CFG_CAPACITY, 0);
    cfg_write(dcwf_pkg::CFG_RADIUS, 32'hFFFFFF);
    send_query(32'h7FFFFFFF, 32'h80000000);
    send_query(32'h80000000, 32'h7FFFFFFF);
    wait_idle();
    cfg_write(dcwf_pkg::CFG_BIN_WIDTH, 3);
    cfg_write(dcwf_pkg::CFG_BIN_HEIGHT, 3);
    cfg_write(dcwf_pkg::CFG_ORIGIN_X, 0);
    cfg_write(dcwf_pkg::CFG_ORIGIN_Y, 0);
    cfg_write(dcwf_pkg::CFG_RADIUS, 5);
    send_query(32'd300, 32'd301);
    send_query(32'd766, 32'd767);
    wait_idle();
  endtask

  task automatic test_random(input int n_items, input int s_pct, input int r_pct);
    int start;
    int steps;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = items_sent;
    steps = 0;
    while (items_sent - start < n_items) begin
      if (steps % 60 == 0) begin
        wait_idle();
        random_setup();
      end
      if ($urandom_range(4) == 0) begin
        write_bin(16'($urandom), $urandom);
      end else begin
        send_query(rand_coord(sh_org_x, sh_bw, sh_cols), rand_coord(sh_org_y, sh_bh, sh_rows));
      end
      steps++;
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(dcwf_pkg::CFG_GRID_COLS, 8);
    cfg_write(dcwf_pkg::CFG_GRID_ROWS, 8);
    cfg_write(dcwf_pkg::CFG_BIN_WIDTH, 10);
    cfg_write(dcwf_pkg::CFG_BIN_HEIGHT, 10);
    cfg_write(dcwf_pkg::CFG_ORIGIN_X, 0);
    cfg_write(dcwf_pkg::CFG_ORIGIN_Y, 0);
    cfg_write(dcwf_pkg::CFG_RADIUS, 25);
    for (int i = 0; i < 64; i++) write_bin(i[15:0], $urandom);
    @(negedge clk);
    in_valid = 1'b0;
    hold_cycles = 3000;
    for (int i = 0; i < 12; i++) send_query($urandom_range(0, 80), $urandom_range(0, 80));
    wait_idle();
  endtask

  initial begin
    sh_cols = 1;
    sh_rows = 1;
    sh_bw = 1;
    sh_bh = 1;
    sh_org_x = 0;
    sh_org_y = 0;
    sh_cap = 0;
    sh_radius = 4;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_random(350, 0, 0);
    test_random(350, 51, 0);
    test_random(350, 0, 51);
    test_random(350, 25, 25);

    @(negedge clk);
    in_valid = 1'b0;
    while (force_q.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
